// ===== rtl/core/ekst_pkg.sv =====
// ---------------------------------------------------------------------------
// Encryption key slot table package
// Shared types, codes and default sizes for the key slot table.
// ---------------------------------------------------------------------------
`default_nettype none

package ekst_pkg;

  // Default sizes handed to the top level parameters.
  localparam int SLOTS_DEF         = 128;
  localparam int MAX_KEY_BYTES_DEF = 32;

  // Register reset value and fixed field widths.
  localparam logic [7:0] ACTIVE_RESET = 8'd128;
  localparam int ID_W       = 32;
  localparam int KEY_WORD_W = 64;
  localparam int KEY_IN_W   = 4 * KEY_WORD_W;
  localparam int KEY_BYTES  = KEY_IN_W / 8;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_DROP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADID = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DREAD,
    S_WRITE,
    S_RESULT
  } state_t;

  // One tag RAM entry.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] owner;
  } tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/ekst_ifs.sv =====
// ---------------------------------------------------------------------------
// Encryption key slot table channels
// Valid/ready channels for commands, results and the slot count register.
// ---------------------------------------------------------------------------
`default_nettype none

interface ekst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] area_id;
  logic [2:0]  method;
  logic [5:0]  key_length;
  logic [63:0] key_word0;
  logic [63:0] key_word1;
  logic [63:0] key_word2;
  logic [63:0] key_word3;

  modport source (
    output valid, command, area_id, method, key_length,
           key_word0, key_word1, key_word2, key_word3,
    input  ready
  );
  modport sink (
    input  valid, command, area_id, method, key_length,
           key_word0, key_word1, key_word2, key_word3,
    output ready
  );
endinterface

interface ekst_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  slot;
  logic [2:0]  found_method;
  logic [5:0]  found_length;
  logic [63:0] out_word0;
  logic [63:0] out_word1;
  logic [63:0] out_word2;
  logic [63:0] out_word3;
  logic [7:0]  entry_total;

  modport source (
    output valid, status, slot, found_method, found_length,
           out_word0, out_word1, out_word2, out_word3, entry_total,
    input  ready
  );
  modport sink (
    input  valid, status, slot, found_method, found_length,
           out_word0, out_word1, out_word2, out_word3, entry_total,
    output ready
  );
endinterface

interface ekst_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ekst_ram.sv =====
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ekst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds until the next read.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/encryption_key_slot_table.sv =====
// ---------------------------------------------------------------------------
// Encryption key slot table
// Key slot manager for inline storage encryption: lookup, store and drop.
// ---------------------------------------------------------------------------
// The table keeps up to SLOTS keys, each tagged with a storage-area id, and
// answers one command word at a time with one result word. Every lookup,
// store or drop with a nonzero id walks the active slots (the smaller of
// the slot count register and SLOTS) one slot per cycle through a single
// tag RAM read port and one id comparator. A hit ends the walk early, a
// store that finds a slot or a drop that finds its id adds a write step,
// and a lookup hit adds a key RAM read. An invalid id or the unused command
// code goes to the result without a walk. Input is taken only while the
// block is idle; a finished result waits in an output register, so the next
// command may start before it is taken. After reset the block clears the
// tag RAM and accepts no command word meanwhile. The slot count register is
// always ready and should be written only while no command is in progress.
// ---------------------------------------------------------------------------
`default_nettype none

module encryption_key_slot_table #(
  parameter int SLOTS         = ekst_pkg::SLOTS_DEF,
  parameter int MAX_KEY_BYTES = ekst_pkg::MAX_KEY_BYTES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ekst_in_if.sink     in_ch,
  ekst_out_if.source  out_ch,
  ekst_cfg_if.sink    cfg_ch
);

  // Slot index width, scan counter width (it must reach n itself) and the
  // width of one key RAM entry: method, length and key bits.
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KB = MAX_KEY_BYTES * 8;
  localparam int DW = KB + 9;
  localparam int TW = $bits(ekst_pkg::tag_t);

  // Sequencer and configuration.
  ekst_pkg::state_t state_r, state_nxt;
  logic [7:0]       cfg_active_r;
  logic [IW-1:0]    clr_idx_r;
  logic [CW-1:0]    scan_lim;

  // Scan pipeline: one read issued per cycle, compared in the cycle after.
  logic [CW-1:0]    issue_idx_r;
  logic             cmp_v_r;
  logic [IW-1:0]    cmp_idx_r;
  logic             free_found_r;
  logic [IW-1:0]    free_idx_r;
  logic             issue;
  logic             cmp_hit;
  logic             scan_end;

  // The command word being worked on.
  ekst_pkg::cmd_t   cmd_r;
  logic [31:0]      id_r;
  logic [2:0]       method_r;
  logic [5:0]       len_r;
  logic [KB-1:0]    key_r;
  logic [5:0]       len_sat;
  logic [ekst_pkg::KEY_IN_W-1:0] key_in;
  logic [ekst_pkg::KEY_IN_W-1:0] key_masked;

  // Result under construction and the occupancy count.
  ekst_pkg::status_t res_status_r;
  logic [IW-1:0]     res_slot_r;
  logic              res_rd_r;
  logic              new_slot_r;
  logic [7:0]        count_r;

  // Output register.
  logic              out_valid_r;
  ekst_pkg::status_t out_status_r;
  logic [6:0]        out_slot_r;
  logic [2:0]        out_method_r;
  logic [5:0]        out_len_r;
  logic [ekst_pkg::KEY_IN_W-1:0] out_key_r;
  logic [7:0]        out_total_r;
  logic              out_load;

  // RAM ports.
  logic              tag_we;
  logic [IW-1:0]     tag_waddr;
  ekst_pkg::tag_t    tag_wdata;
  logic              tag_re;
  logic [TW-1:0]     tag_rdata;
  ekst_pkg::tag_t    tag_q;
  logic              dat_we;
  logic              dat_re;
  logic [DW-1:0]     dat_q;

  // The register is a plain write port; it is always ready.
  assign cfg_ch.ready = 1'b1;

  // Slot count above SLOTS acts as SLOTS.
  assign scan_lim = (32'(cfg_active_r) > SLOTS) ? CW'(SLOTS) : CW'(cfg_active_r);

  // An overlong key is cut to the maximum; bytes at or beyond the length
  // are stored as zero.
  assign len_sat = (in_ch.key_length > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES)
                                                           : in_ch.key_length;
  assign key_in  = {in_ch.key_word3, in_ch.key_word2, in_ch.key_word1, in_ch.key_word0};

  always_comb begin
    for (int b = 0; b < ekst_pkg::KEY_BYTES; b++) begin
      key_masked[8*b +: 8] = (6'(b) < len_sat) ? key_in[8*b +: 8] : 8'h00;
    end
  end

  assign tag_q   = ekst_pkg::tag_t'(tag_rdata);
  assign cmp_hit = (state_r == ekst_pkg::S_SCAN) && cmp_v_r && tag_q.valid &&
                   (tag_q.owner == id_r);
  assign scan_end = (state_r == ekst_pkg::S_SCAN) && !cmp_v_r &&
                    !(issue_idx_r < scan_lim);
  assign out_load = (state_r == ekst_pkg::S_RESULT) && (!out_valid_r || out_ch.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ekst_pkg::S_CLEAR: begin
        if (clr_idx_r == IW'(SLOTS - 1)) begin
          state_nxt = ekst_pkg::S_IDLE;
        end
      end
      ekst_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          if (ekst_pkg::cmd_t'(in_ch.command) == ekst_pkg::CMD_NONE ||
              in_ch.area_id == 32'd0) begin
            state_nxt = ekst_pkg::S_RESULT;
          end else begin
            state_nxt = ekst_pkg::S_SCAN;
          end
        end
      end
      ekst_pkg::S_SCAN: begin
        if (cmp_hit) begin
          state_nxt = (cmd_r == ekst_pkg::CMD_LOOKUP) ? ekst_pkg::S_DREAD
                                                      : ekst_pkg::S_WRITE;
        end else if (scan_end) begin
          state_nxt = (cmd_r == ekst_pkg::CMD_STORE && free_found_r) ? ekst_pkg::S_WRITE
                                                                     : ekst_pkg::S_RESULT;
        end
      end
      ekst_pkg::S_DREAD:  state_nxt = ekst_pkg::S_RESULT;
      ekst_pkg::S_WRITE:  state_nxt = ekst_pkg::S_RESULT;
      ekst_pkg::S_RESULT: begin
        if (out_load) begin
          state_nxt = ekst_pkg::S_IDLE;
        end
      end
      default: state_nxt = ekst_pkg::S_CLEAR;
    endcase
  end

  // Sequencer outputs: handshake and RAM controls.
  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    tag_we      = 1'b0;
    tag_waddr   = res_slot_r;
    tag_wdata   = '0;
    tag_re      = 1'b0;
    dat_we      = 1'b0;
    dat_re      = 1'b0;
    case (state_r)
      ekst_pkg::S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_idx_r;
      end
      ekst_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ekst_pkg::S_SCAN: begin
        issue  = (issue_idx_r < scan_lim) && !cmp_hit;
        tag_re = issue;
      end
      ekst_pkg::S_DREAD: begin
        dat_re = 1'b1;
      end
      ekst_pkg::S_WRITE: begin
        tag_we = 1'b1;
        if (cmd_r == ekst_pkg::CMD_STORE) begin
          tag_wdata.valid = 1'b1;
          tag_wdata.owner = id_r;
          dat_we          = 1'b1;
        end
      end
      ekst_pkg::S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ekst_pkg::S_CLEAR;
      cfg_active_r <= ekst_pkg::ACTIVE_RESET;
      clr_idx_r    <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      cmp_v_r      <= 1'b0;
      issue_idx_r  <= '0;
      free_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        cfg_active_r <= cfg_ch.data;
      end
      if (state_r == ekst_pkg::S_CLEAR) begin
        clr_idx_r <= clr_idx_r + IW'(1);
      end
      if (in_ch.valid && in_ch.ready) begin
        issue_idx_r  <= '0;
        free_found_r <= 1'b0;
      end
      cmp_v_r <= issue;
      if (issue) begin
        issue_idx_r <= issue_idx_r + CW'(1);
      end
      // Remember the lowest free slot in case no slot holds the id.
      if (cmp_v_r && (state_r == ekst_pkg::S_SCAN) && !tag_q.valid && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (state_r == ekst_pkg::S_WRITE) begin
        if (cmd_r == ekst_pkg::CMD_STORE) begin
          if (new_slot_r && count_r != 8'hFF) begin
            count_r <= count_r + 8'd1;
          end
        end else if (count_r != 8'd0) begin
          count_r <= count_r - 8'd1;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r      <= ekst_pkg::cmd_t'(in_ch.command);
      id_r       <= in_ch.area_id;
      method_r   <= in_ch.method;
      len_r      <= len_sat;
      key_r      <= key_masked[KB-1:0];
      res_slot_r <= '0;
      res_rd_r   <= 1'b0;
      new_slot_r <= 1'b0;
      if (in_ch.area_id == 32'd0 &&
          ekst_pkg::cmd_t'(in_ch.command) != ekst_pkg::CMD_NONE) begin
        res_status_r <= ekst_pkg::ST_BADID;
      end else begin
        res_status_r <= ekst_pkg::ST_MISS;
      end
    end
    cmp_idx_r <= issue_idx_r[IW-1:0];
    if (cmp_v_r && (state_r == ekst_pkg::S_SCAN) && !tag_q.valid && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (cmp_hit) begin
      res_slot_r   <= cmp_idx_r;
      res_status_r <= ekst_pkg::ST_OK;
    end else if (scan_end && cmd_r == ekst_pkg::CMD_STORE) begin
      if (free_found_r) begin
        res_slot_r   <= free_idx_r;
        res_status_r <= ekst_pkg::ST_OK;
        new_slot_r   <= 1'b1;
      end else begin
        res_status_r <= ekst_pkg::ST_FULL;
      end
    end
    if (state_r == ekst_pkg::S_DREAD) begin
      res_rd_r <= 1'b1;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= 7'(res_slot_r);
      out_total_r  <= count_r;
      if (res_rd_r) begin
        out_method_r <= dat_q[DW-1 -: 3];
        out_len_r    <= dat_q[KB +: 6];
        out_key_r    <= ekst_pkg::KEY_IN_W'(dat_q[KB-1:0]);
      end else begin
        out_method_r <= '0;
        out_len_r    <= '0;
        out_key_r    <= '0;
      end
    end
  end

  // Tag RAM: valid bit and owner id per slot.
  ekst_ram #(
    .WIDTH (TW),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .re    (tag_re),
    .raddr (issue_idx_r[IW-1:0]),
    .rdata (tag_rdata)
  );

  // Key RAM: method, length and key bytes per slot. A drop only clears the
  // tag, since key data is read only from a valid slot.
  ekst_ram #(
    .WIDTH (DW),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (res_slot_r),
    .wdata ({method_r, len_r, key_r}),
    .re    (dat_re),
    .raddr (res_slot_r),
    .rdata (dat_q)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.slot         = out_slot_r;
  assign out_ch.found_method = out_method_r;
  assign out_ch.found_length = out_len_r;
  assign out_ch.out_word0    = out_key_r[63:0];
  assign out_ch.out_word1    = out_key_r[127:64];
  assign out_ch.out_word2    = out_key_r[191:128];
  assign out_ch.out_word3    = out_key_r[255:192];
  assign out_ch.entry_total  = out_total_r;

`ifndef SYNTH
  // The count tracks the valid slots, so it never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= SLOTS)
    else $error("occupied count exceeds the slot count");

  // The count moves only in the write step.
  a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r != ekst_pkg::S_WRITE) |=> $stable(count_r))
    else $error("occupied count changed outside a write");

  // A key read follows only a hit.
  a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ekst_pkg::S_DREAD) |-> (res_status_r == ekst_pkg::ST_OK))
    else $error("key read without a hit");

  // Compared slots stay within the active range.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmp_v_r && state_r == ekst_pkg::S_SCAN) |-> (CW'(cmp_idx_r) < scan_lim))
    else $error("scan compared a slot beyond the active range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_encryption_key_slot_table.sv =====
// ---------------------------------------------------------------------------
// Key slot table testbench
// Drives lookup, store and drop command words into the key slot table, keeps
// a model of the slot contents and checks every result word against it while
// the slot count register is moved through several settings.
// ---------------------------------------------------------------------------
module tb_encryption_key_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ekst_pkg::*;

  localparam int NSLOTS  = SLOTS_DEF;
  localparam int MAX_KEY = MAX_KEY_BYTES_DEF;

  // The slowest correct gap between two handshakes is a full 128-slot walk
  // plus the longest sender gap and the longest receiver stall. The clearing
  // pass after reset and the long receiver hold-off must also fit within it.
  // The limit leaves a wide margin on all.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 600;
  localparam int TAIL_CYCLES    = 200;
  localparam int POOL_SIZE      = 24;

  // One command word as offered on the input channel.
  typedef struct packed {
    cmd_t             command;
    logic [31:0]      area_id;
    logic [2:0]       method;
    logic [5:0]       key_length;
    logic [3:0][63:0] key;
  } key_cmd_t;

  // One result word as it should appear on the output channel.
  typedef struct packed {
    status_t          status;
    logic [6:0]       slot;
    logic [2:0]       method;
    logic [5:0]       length;
    logic [3:0][63:0] key;
    logic [7:0]       entry_total;
  } key_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  ekst_in_if  in_ch();
  ekst_out_if out_ch();
  ekst_cfg_if cfg_ch();

  encryption_key_slot_table uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  // Model of the slot table. It is updated when a command word is accepted,
  // so its order always follows the order seen by the block.
  logic [31:0]      tbl_owner  [NSLOTS];
  logic             tbl_valid  [NSLOTS];
  logic [2:0]       tbl_method [NSLOTS];
  logic [5:0]       tbl_len    [NSLOTS];
  logic [3:0][63:0] tbl_key    [NSLOTS];
  int               occupied;
  logic [7:0]       slot_count;

  key_cmd_t    pending_cmds[$];
  key_answer_t expected_answers[$];
  logic [31:0] id_pool [POOL_SIZE];

  // Sender state. The word on offer stays on the channel until it is taken.
  key_cmd_t offer_item = '0;
  bit       offer_live = 1'b0;
  int       send_gap   = 0;

  // Receiver state and the chance, in percent, that a burst of idling starts.
  int recv_hold       = 0;
  bit hold_off_request = 1'b0;
  int idle_chance     = 0;

  int error_count = 0;

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    flag_error($sformatf("%s mismatch: expected %h, got %h", name, want, got));
  endtask

  // Scans the active slots in index order for a valid slot holding the id.
  function automatic int find_owner(input logic [31:0] id, input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (tbl_valid[i] && tbl_owner[i] == id) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Applies one command to the table model and returns the result word.
  function automatic key_answer_t predict_answer(input key_cmd_t c);
    key_answer_t a;
    int          n;
    int          hit;
    int          len;
    int          i;
    int          w;
    int          base;
    logic [63:0] m;
    a = '0;
    a.status = ST_MISS;
    len = (c.key_length > MAX_KEY) ? MAX_KEY : int'(c.key_length);
    n = (slot_count > NSLOTS) ? NSLOTS : int'(slot_count);
    hit = find_owner(c.area_id, n);
    if (c.area_id == '0 && c.command != CMD_NONE) begin
      a.status = ST_BADID;
    end else if (c.command == CMD_LOOKUP) begin
      if (hit >= 0) begin
        a.status = ST_OK;
        a.slot   = 7'(hit);
        a.method = tbl_method[hit];
        a.length = tbl_len[hit];
        a.key    = tbl_key[hit];
      end
    end else if (c.command == CMD_STORE) begin
      // A new id takes the lowest free active slot; only then does the
      // occupied count move.
      if (hit < 0) begin
        for (i = 0; i < n && hit < 0; i++) begin
          if (!tbl_valid[i]) begin
            hit = i;
          end
        end
        if (hit >= 0 && occupied < 255) begin
          occupied++;
        end
      end
      if (hit < 0) begin
        a.status = ST_FULL;
      end else begin
        a.status = ST_OK;
        a.slot   = 7'(hit);
        tbl_owner[hit]  = c.area_id;
        tbl_valid[hit]  = 1'b1;
        tbl_method[hit] = c.method;
        tbl_len[hit]    = 6'(len);
        // Key bytes at or past the stored length are kept as zero.
        for (w = 0; w < 4; w++) begin
          base = 8 * w;
          if (len <= base) begin
            m = '0;
          end else if (len - base >= 8) begin
            m = '1;
          end else begin
            m = (64'd1 << (8 * (len - base))) - 64'd1;
          end
          tbl_key[hit][w] = c.key[w] & m;
        end
      end
    end else if (c.command == CMD_DROP) begin
      if (hit >= 0) begin
        a.status = ST_OK;
        a.slot   = 7'(hit);
        tbl_owner[hit] = '0;
        tbl_valid[hit] = 1'b0;
        tbl_len[hit]   = '0;
        tbl_key[hit]   = '0;
        if (occupied > 0) begin
          occupied--;
        end
      end
    end
    a.entry_total = 8'(occupied);
    return a;
  endfunction

  function automatic key_cmd_t make_cmd(input cmd_t op, input logic [31:0] id,
                                        input logic [2:0] meth,
                                        input logic [5:0] len,
                                        input logic [3:0][63:0] key);
    key_cmd_t c;
    c.command    = op;
    c.area_id    = id;
    c.method     = meth;
    c.key_length = len;
    c.key        = key;
    return c;
  endfunction

  // Mostly well-formed traffic on a small id pool, so that stores, hits and
  // drops keep meeting each other, with some invalid ids, unused command
  // codes and random ids mixed in.
  function automatic key_cmd_t random_cmd(input int pool);
    key_cmd_t c;
    int       r;
    int       k;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    c.area_id = id_pool[$urandom_range(0, pool - 1)];
    if (k < 40) begin
      c.command = CMD_STORE;
    end else if (k < 75) begin
      c.command = CMD_LOOKUP;
    end else begin
      c.command = CMD_DROP;
    end
    if (r < 5) begin
      c.area_id = '0;
      c.command = cmd_t'($urandom_range(0, 3));
    end else if (r < 9) begin
      c.command = CMD_NONE;
    end else if (r < 13) begin
      c.area_id = $urandom;
    end
    c.method = 3'($urandom_range(0, 7));
    k = $urandom_range(0, 99);
    if (k < 3) begin
      c.key_length = '0;
    end else if (k < 13) begin
      c.key_length = 6'($urandom_range(33, 63));
    end else begin
      c.key_length = 6'($urandom_range(1, 32));
    end
    c.key = {$urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
    return c;
  endfunction

  // Waits until every queued command word has been taken and every
  // expected result word has come back, so the block is idle.
  task automatic wait_for_idle();
    while (pending_cmds.size() != 0 || offer_live || expected_answers.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_slot_count(input logic [7:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do begin
      @(posedge clk);
    end while (cfg_ch.ready !== 1'b1);
    slot_count = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // One random phase: settle, set the slot count, then queue the words.
  // When squeeze is set the receiver holds off for a long stretch while the
  // sender keeps offering, so the output register fills and input stalls.
  task automatic run_random(input logic [7:0] count, input int items, input int pool,
                            input int idle_pct, input bit squeeze);
    wait_for_idle();
    write_slot_count(count);
    idle_chance = idle_pct;
    if (squeeze) begin
      hold_off_request = 1'b1;
    end
    repeat (items) begin
      pending_cmds.push_back(random_cmd(pool));
    end
  endtask

  // Sender: a new word is put on the channel at the falling edge only when
  // the previous one has been taken, after an optional random gap.
  always @(negedge clk) begin
    if (rst_n && !offer_live) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_cmds.size() > 0) begin
        offer_item = pending_cmds.pop_front();
        offer_live = 1'b1;
        if ($urandom_range(1, 100) <= idle_chance) begin
          send_gap = $urandom_range(1, 15);
        end
      end
    end
    in_ch.valid      <= offer_live;
    in_ch.command    <= offer_item.command;
    in_ch.area_id    <= offer_item.area_id;
    in_ch.method     <= offer_item.method;
    in_ch.key_length <= offer_item.key_length;
    in_ch.key_word0  <= offer_item.key[0];
    in_ch.key_word1  <= offer_item.key[1];
    in_ch.key_word2  <= offer_item.key[2];
    in_ch.key_word3  <= offer_item.key[3];
  end

  // A command word is taken at a rising edge with valid and ready high.
  // Its result is predicted right away, in acceptance order.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      expected_answers.push_back(predict_answer(offer_item));
      offer_live = 1'b0;
    end
  end

  // Receiver: ready drops for random bursts, or for the long hold-off when
  // one is requested.
  always @(negedge clk) begin
    if (hold_off_request) begin
      recv_hold        = LONG_HOLD;
      hold_off_request = 1'b0;
    end
    if (recv_hold > 0) begin
      recv_hold--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(1, 100) <= idle_chance) begin
      recv_hold = $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Result monitor: every word taken is checked field by field against the
  // oldest outstanding prediction.
  always @(posedge clk) begin : result_monitor
    key_answer_t got;
    key_answer_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status      = status_t'(out_ch.status);
      got.slot        = out_ch.slot;
      got.method      = out_ch.found_method;
      got.length      = out_ch.found_length;
      got.key[0]      = out_ch.out_word0;
      got.key[1]      = out_ch.out_word1;
      got.key[2]      = out_ch.out_word2;
      got.key[3]      = out_ch.out_word3;
      got.entry_total = out_ch.entry_total;
      if (expected_answers.size() == 0) begin
        flag_error("result word arrived with no command outstanding");
      end else begin
        want = expected_answers.pop_front();
        if (got.status !== want.status) begin
          report_field("status", 64'(want.status), 64'(got.status));
        end
        if (got.slot !== want.slot) begin
          report_field("slot", 64'(want.slot), 64'(got.slot));
        end
        if (got.method !== want.method) begin
          report_field("found_method", 64'(want.method), 64'(got.method));
        end
        if (got.length !== want.length) begin
          report_field("found_length", 64'(want.length), 64'(got.length));
        end
        for (int w = 0; w < 4; w++) begin
          if (got.key[w] !== want.key[w]) begin
            report_field($sformatf("out_word%0d", w), want.key[w], got.key[w]);
          end
        end
        if (got.entry_total !== want.entry_total) begin
          report_field("entry_total", 64'(want.entry_total), 64'(got.entry_total));
        end
      end
    end
  end

  // Watchdog: ends the run when no word has moved on any channel for too
  // long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    logic [31:0]      id_a;
    logic [31:0]      id_b;
    logic [31:0]      id_c;
    logic [31:0]      id_d;
    logic [31:0]      id_e;
    logic [31:0]      id_f;
    logic [3:0][63:0] ones;
    logic [3:0][63:0] zeros;
    int               i;

    // Every block input is known from time zero.
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_LOOKUP;
    in_ch.area_id    = '0;
    in_ch.method     = '0;
    in_ch.key_length = '0;
    in_ch.key_word0  = '0;
    in_ch.key_word1  = '0;
    in_ch.key_word2  = '0;
    in_ch.key_word3  = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;

    // The model starts empty, like the block after its clearing pass.
    for (i = 0; i < NSLOTS; i++) begin
      tbl_owner[i]  = '0;
      tbl_valid[i]  = 1'b0;
      tbl_method[i] = '0;
      tbl_len[i]    = '0;
      tbl_key[i]    = '0;
    end
    occupied   = 0;
    slot_count = ACTIVE_RESET;

    // The id pool always holds the two extreme ids; the rest are random
    // and never zero.
    id_pool[0] = 32'hFFFF_FFFF;
    id_pool[1] = 32'h0000_0001;
    for (i = 2; i < POOL_SIZE; i++) begin
      do begin
        id_pool[i] = $urandom;
      end while (id_pool[i] == '0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on a four-slot table: invalid ids, the unused command
    // code, filling the table until it reports full, overlong and empty
    // keys, overwrite of a held id, and reuse of a dropped slot.
    id_a  = 32'h0000_0001;
    id_b  = 32'hFFFF_FFFF;
    id_c  = 32'h8000_0000;
    id_d  = 32'h7FFF_FFFE;
    id_e  = 32'h5A5A_A5A5;
    id_f  = 32'h0000_0100;
    ones  = '1;
    zeros = '0;
    idle_chance = 10;
    write_slot_count(8'd4);
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_a, 3'd0, 6'd1, zeros));
    pending_cmds.push_back(make_cmd(CMD_DROP, id_a, 3'd0, 6'd1, zeros));
    pending_cmds.push_back(make_cmd(CMD_STORE, '0, 3'd7, 6'd32, ones));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, '0, 3'd0, 6'd1, zeros));
    pending_cmds.push_back(make_cmd(CMD_DROP, '0, 3'd0, 6'd1, zeros));
    pending_cmds.push_back(make_cmd(CMD_NONE, '0, 3'd0, 6'd1, zeros));
    pending_cmds.push_back(make_cmd(CMD_NONE, id_a, 3'd7, 6'd32, ones));
    pending_cmds.push_back(make_cmd(CMD_STORE, id_a, 3'd7, 6'd32, ones));
    pending_cmds.push_back(make_cmd(CMD_STORE, id_b, 3'd0, 6'd1, ones));
    pending_cmds.push_back(make_cmd(CMD_STORE, id_c, 3'd5, 6'd63,
                                    {$urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom}));
    pending_cmds.push_back(make_cmd(CMD_STORE, id_d, 3'd3, 6'd0, ones));
    pending_cmds.push_back(make_cmd(CMD_STORE, id_e, 3'd4, 6'd16, ones));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_a, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_b, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_c, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_d, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_STORE, id_a, 3'd2, 6'd13, ones));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_a, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_DROP, id_b, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_DROP, id_b, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_b, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_STORE, id_e, 3'd6, 6'd20,
                                    {$urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom}));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_e, 3'd0, 6'd0, zeros));
    pending_cmds.push_back(make_cmd(CMD_STORE, id_f, 3'd1, 6'd8, zeros));
    pending_cmds.push_back(make_cmd(CMD_LOOKUP, id_f, 3'd0, 6'd0, zeros));

    // Random phases. A count of zero leaves no slot at all, 255 acts as the
    // full table, and shrinking from eight to three hides occupied slots
    // that come back into view when the count grows again. Most phases keep
    // the table small so that walks stay short.
    run_random(8'd0,   12,  4,  8,  1'b0);
    run_random(8'd1,   40,  3,  0,  1'b0);
    run_random(8'd255, 50,  6,  6,  1'b0);
    run_random(8'd8,   140, 12, 12, 1'b0);
    run_random(8'd3,   70,  12, 8,  1'b0);
    run_random(8'd128, 60,  20, 5,  1'b1);
    // The last phase runs with no idling on either side.
    run_random(8'd16,  180, POOL_SIZE, 0, 1'b0);

    wait_for_idle();
    // Let the block sit for longer than one full walk, so that a stray
    // result word would still be seen by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_answers.size() != 0) begin
      flag_error("predicted results left over at the end of the run");
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
